FILE: hw/rtl/pidsw_pkg.sv
// types, constants and microcode program of the pid setpoint-weighting controller
package pidsw_pkg;

    localparam int COEF_W    = 16;
    localparam int CHUNK_W   = 32;
    localparam int SLOT_W    = 3;
    localparam int RAM_DEPTH = 8;
    localparam int PC_W      = 6;
    localparam int REG_IDX_W = 3;

    localparam logic [COEF_W-1:0] RESET_GAIN     = 16'd3932;
    localparam logic [COEF_W-1:0] RESET_WEIGHT   = 16'd2048;
    localparam logic [COEF_W-1:0] RESET_INTEGRAL = 16'd197;
    localparam logic [COEF_W-1:0] RESET_DECAY    = 16'd1841;
    localparam logic [COEF_W-1:0] RESET_DGAIN    = 16'd17678;

    typedef enum logic [3:0] {
        OP_NOP  = 4'd0,
        OP_ZERO = 4'd1,
        OP_ADD  = 4'd2,
        OP_SUB  = 4'd3,
        OP_MOV  = 4'd4,
        OP_ABS  = 4'd5,
        OP_MUL  = 4'd6,
        OP_RND  = 4'd7,
        OP_SGN  = 4'd8,
        OP_WAIT = 4'd9,
        OP_OUT  = 4'd10
    } op_t;

    typedef enum logic [2:0] {
        JMP_NEXT     = 3'd0,
        JMP_ALWAYS   = 3'd1,
        JMP_MUL_MORE = 3'd2,
        JMP_WAIT_IN  = 3'd3,
        JMP_OUT      = 3'd4
    } jump_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN     = 3'd0,
        REG_WEIGHT   = 3'd1,
        REG_INTEGRAL = 3'd2,
        REG_DECAY    = 3'd3,
        REG_DGAIN    = 3'd4
    } reg_idx_t;

    typedef enum logic [SLOT_W-1:0] {
        SLOT_PREV = 3'd0,
        SLOT_IACC = 3'd1,
        SLOT_DACC = 3'd2,
        SLOT_T0   = 3'd3,
        SLOT_T1   = 3'd4,
        SLOT_T2   = 3'd5,
        SLOT_T3   = 3'd6
    } slot_t;

    typedef struct packed {
        op_t             op;
        logic            a_in;
        logic            b_in;
        slot_t           dst;
        slot_t           rd_a;
        slot_t           rd_b;
        reg_idx_t        coef;
        logic            u_load;
        jump_t           jump;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic mul_more;
        logic out_free;
    } cond_t;

    typedef struct packed {
        logic [COEF_W-1:0] gain;
        logic [COEF_W-1:0] weight;
        logic [COEF_W-1:0] integral;
        logic [COEF_W-1:0] decay;
        logic [COEF_W-1:0] dgain;
    } coefs_t;

    localparam logic [PC_W-1:0] STEP_IDLE = 6'd3;

    function automatic ctrl_t mk(op_t op, logic a_in, logic b_in, slot_t dst, slot_t rd_a,
                                 slot_t rd_b, reg_idx_t coef, logic u_load, jump_t jump,
                                 logic [PC_W-1:0] target);
        ctrl_t c;
        c.op     = op;
        c.a_in   = a_in;
        c.b_in   = b_in;
        c.dst    = dst;
        c.rd_a   = rd_a;
        c.rd_b   = rd_b;
        c.coef   = coef;
        c.u_load = u_load;
        c.jump   = jump;
        c.target = target;
        return c;
    endfunction

    // read addresses issued in a step feed the operands of the following step
    function automatic ctrl_t rom(logic [PC_W-1:0] pc);
        ctrl_t c;
        case (pc)
            // clearing pass of the state slots after reset
            6'd0:  c = mk(OP_ZERO, 1'b0, 1'b0, SLOT_PREV, SLOT_T0, SLOT_T0, REG_GAIN, 1'b0,
                          JMP_NEXT, '0);
            6'd1:  c = mk(OP_ZERO, 1'b0, 1'b0, SLOT_IACC, SLOT_T0, SLOT_T0, REG_GAIN, 1'b0,
                          JMP_NEXT, '0);
            6'd2:  c = mk(OP_ZERO, 1'b0, 1'b0, SLOT_DACC, SLOT_T0, SLOT_T0, REG_GAIN, 1'b0,
                          JMP_NEXT, '0);
            6'd3:  c = mk(OP_WAIT, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_GAIN, 1'b0,
                          JMP_WAIT_IN, STEP_IDLE);
            // weighted reference
            6'd4:  c = mk(OP_ABS, 1'b1, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_WEIGHT, 1'b0,
                          JMP_NEXT, '0);
            6'd5:  c = mk(OP_MUL, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_WEIGHT, 1'b0,
                          JMP_MUL_MORE, 6'd5);
            6'd6:  c = mk(OP_RND, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_WEIGHT, 1'b0,
                          JMP_NEXT, '0);
            6'd7:  c = mk(OP_SGN, 1'b0, 1'b0, SLOT_T0, SLOT_PREV, SLOT_T0, REG_WEIGHT, 1'b0,
                          JMP_NEXT, '0);
            // measurement step and proportional error
            6'd8:  c = mk(OP_SUB, 1'b0, 1'b1, SLOT_T2, SLOT_T0, SLOT_T0, REG_GAIN, 1'b0,
                          JMP_NEXT, '0);
            6'd9:  c = mk(OP_SUB, 1'b0, 1'b1, SLOT_T0, SLOT_DACC, SLOT_T0, REG_GAIN, 1'b0,
                          JMP_NEXT, '0);
            // decayed derivative
            6'd10: c = mk(OP_ABS, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_DECAY, 1'b0,
                          JMP_NEXT, '0);
            6'd11: c = mk(OP_MUL, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_DECAY, 1'b0,
                          JMP_MUL_MORE, 6'd11);
            6'd12: c = mk(OP_RND, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_DECAY, 1'b0,
                          JMP_NEXT, '0);
            6'd13: c = mk(OP_SGN, 1'b0, 1'b0, SLOT_T3, SLOT_T0, SLOT_T0, REG_DECAY, 1'b0,
                          JMP_NEXT, '0);
            // proportional term
            6'd14: c = mk(OP_ABS, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_GAIN, 1'b0,
                          JMP_NEXT, '0);
            6'd15: c = mk(OP_MUL, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_GAIN, 1'b0,
                          JMP_MUL_MORE, 6'd15);
            6'd16: c = mk(OP_RND, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_GAIN, 1'b0,
                          JMP_NEXT, '0);
            6'd17: c = mk(OP_SGN, 1'b0, 1'b0, SLOT_T1, SLOT_T2, SLOT_T0, REG_GAIN, 1'b0,
                          JMP_NEXT, '0);
            // derivative input term
            6'd18: c = mk(OP_ABS, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_DGAIN, 1'b0,
                          JMP_NEXT, '0);
            6'd19: c = mk(OP_MUL, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_DGAIN, 1'b0,
                          JMP_MUL_MORE, 6'd19);
            6'd20: c = mk(OP_RND, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_DGAIN, 1'b0,
                          JMP_NEXT, '0);
            6'd21: c = mk(OP_SGN, 1'b0, 1'b0, SLOT_T2, SLOT_T1, SLOT_IACC, REG_DGAIN, 1'b0,
                          JMP_NEXT, '0);
            // sums
            6'd22: c = mk(OP_ADD, 1'b0, 1'b0, SLOT_T1, SLOT_T3, SLOT_T2, REG_GAIN, 1'b0,
                          JMP_NEXT, '0);
            6'd23: c = mk(OP_ADD, 1'b0, 1'b0, SLOT_DACC, SLOT_T0, SLOT_T0, REG_GAIN, 1'b0,
                          JMP_NEXT, '0);
            6'd24: c = mk(OP_SUB, 1'b1, 1'b1, SLOT_T0, SLOT_T1, SLOT_DACC, REG_GAIN, 1'b0,
                          JMP_NEXT, '0);
            6'd25: c = mk(OP_ADD, 1'b0, 1'b0, SLOT_T1, SLOT_T0, SLOT_T0, REG_GAIN, 1'b1,
                          JMP_NEXT, '0);
            // integral update
            6'd26: c = mk(OP_ABS, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_INTEGRAL, 1'b0,
                          JMP_NEXT, '0);
            6'd27: c = mk(OP_MUL, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_INTEGRAL, 1'b0,
                          JMP_MUL_MORE, 6'd27);
            6'd28: c = mk(OP_RND, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_INTEGRAL, 1'b0,
                          JMP_NEXT, '0);
            6'd29: c = mk(OP_SGN, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_INTEGRAL, 1'b0,
                          JMP_NEXT, '0);
            6'd30: c = mk(OP_MOV, 1'b0, 1'b1, SLOT_PREV, SLOT_IACC, SLOT_T0, REG_GAIN, 1'b0,
                          JMP_NEXT, '0);
            6'd31: c = mk(OP_ADD, 1'b0, 1'b0, SLOT_IACC, SLOT_T0, SLOT_T0, REG_GAIN, 1'b0,
                          JMP_NEXT, '0);
            6'd32: c = mk(OP_OUT, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_GAIN, 1'b0,
                          JMP_OUT, STEP_IDLE);
            default: c = mk(OP_NOP, 1'b0, 1'b0, SLOT_T0, SLOT_T0, SLOT_T0, REG_GAIN, 1'b0,
                            JMP_ALWAYS, STEP_IDLE);
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/pidsw_ram.sv
// generic ram, one write port and two registered read ports
module pidsw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: hw/rtl/pidsw_sequencer.sv
// step counter and control store of the pid microcode
module pidsw_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  pidsw_pkg::cond_t  cond,
    output pidsw_pkg::ctrl_t  ctrl
);

    logic [pidsw_pkg::PC_W-1:0] pc_reg;
    logic [pidsw_pkg::PC_W-1:0] pc_next;
    logic [pidsw_pkg::PC_W-1:0] pc_inc;

    assign ctrl   = pidsw_pkg::rom(pc_reg);
    assign pc_inc = pc_reg + 1'b1;

    always_comb
    begin
        case (ctrl.jump)
            pidsw_pkg::JMP_NEXT:     pc_next = pc_inc;
            pidsw_pkg::JMP_ALWAYS:   pc_next = ctrl.target;
            pidsw_pkg::JMP_MUL_MORE: pc_next = cond.mul_more ? ctrl.target : pc_inc;
            pidsw_pkg::JMP_WAIT_IN:  pc_next = cond.in_valid ? pc_inc : ctrl.target;
            pidsw_pkg::JMP_OUT:      pc_next = cond.out_free ? ctrl.target : pc_reg;
            default:                 pc_next = pidsw_pkg::STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: hw/rtl/pidsw_datapath.sv
// datapath of the pid controller: slot ram, saturating alu, chunked coefficient multiplier
module pidsw_datapath #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int ACC_WIDTH      = 32,
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pidsw_pkg::ctrl_t               ctrl,
    input  pidsw_pkg::coefs_t              coefs,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] in_reference,
    input  logic signed [SAMPLE_WIDTH-1:0] in_measurement,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] out_value,
    output logic                           out_sat,
    output pidsw_pkg::cond_t               cond
);

    localparam int DW   = (ACC_WIDTH > SAMPLE_WIDTH) ? ACC_WIDTH : SAMPLE_WIDTH;
    localparam int CW   = pidsw_pkg::CHUNK_W;
    localparam int NCH  = (DW + CW - 1) / CW;
    localparam int MW   = NCH * CW;
    localparam int PWW  = MW + pidsw_pkg::COEF_W;
    localparam int PW   = CW + pidsw_pkg::COEF_W;
    localparam int CNTW = (NCH > 1) ? $clog2(NCH) : 1;

    localparam logic signed [DW:0] ACC_MAX =
        {{(DW - ACC_WIDTH + 2){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
    localparam logic signed [DW:0] ACC_MIN = ~ACC_MAX;
    localparam logic [PWW:0] LIM_POS = (PWW + 1)'({(ACC_WIDTH - 1){1'b1}});
    localparam logic [PWW:0] HALF = (PWW + 1)'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [DW-1:0] SMAX = DW'({(SAMPLE_WIDTH - 1){1'b1}});
    localparam logic signed [DW-1:0] SMIN = ~SMAX;

    logic signed [SAMPLE_WIDTH-1:0]   r_reg, r_next, y_reg, y_next;
    logic                             sign_reg, sign_next;
    logic [MW-1:0]                    mag_reg, mag_next;
    logic [PWW-1:0]                   prod_reg, prod_next;
    logic [CNTW-1:0]                  cnt_reg, cnt_next;
    logic [pidsw_pkg::COEF_W-1:0]     coef_reg, coef_next, coef_sel;
    logic [ACC_WIDTH-1:0]             rnd_reg, rnd_next;
    logic signed [DW-1:0]             u_reg, u_next;
    logic                             out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0]   out_value_reg, out_value_next;
    logic                             out_sat_reg, out_sat_next;

    logic signed [DW-1:0] ram_qa, ram_qb, a_op, b_op, alu_res, sgn_val, ram_wdata;
    logic signed [DW:0]   a_ext, b_ext, alu_wide, mag_ext;
    logic [DW-1:0]        abs_val;
    logic [PW-1:0]        part;
    logic [PWW:0]         rnd_sum, lim;
    logic                 ram_we, out_free, out_load;

    assign in_ready = (ctrl.op == pidsw_pkg::OP_WAIT);

    assign a_op = ctrl.a_in ? DW'(r_reg) : ram_qa;
    assign b_op = ctrl.b_in ? DW'(y_reg) : ram_qb;

    // saturating add and subtract
    assign a_ext    = (DW + 1)'(a_op);
    assign b_ext    = (DW + 1)'(b_op);
    assign alu_wide = (ctrl.op == pidsw_pkg::OP_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);

    always_comb
    begin
        if (alu_wide > ACC_MAX)
        begin
            alu_res = DW'(ACC_MAX);
        end
        else if (alu_wide < ACC_MIN)
        begin
            alu_res = DW'(ACC_MIN);
        end
        else
        begin
            alu_res = DW'(alu_wide);
        end
    end

    // coefficient product: magnitude times coefficient, top chunk first
    assign abs_val = a_op[DW-1] ? $unsigned(DW'(-a_op)) : $unsigned(a_op);
    assign part    = mag_reg[MW-1 -: CW] * coef_reg;
    assign rnd_sum = ({1'b0, prod_reg} + HALF) >> COEF_FRAC_BITS;
    assign lim     = LIM_POS + (PWW + 1)'(sign_reg);
    assign mag_ext = $signed((DW + 1)'(rnd_reg));
    assign sgn_val = DW'(sign_reg ? -mag_ext : mag_ext);

    always_comb
    begin
        case (ctrl.coef)
            pidsw_pkg::REG_GAIN:     coef_sel = coefs.gain;
            pidsw_pkg::REG_WEIGHT:   coef_sel = coefs.weight;
            pidsw_pkg::REG_INTEGRAL: coef_sel = coefs.integral;
            pidsw_pkg::REG_DECAY:    coef_sel = coefs.decay;
            pidsw_pkg::REG_DGAIN:    coef_sel = coefs.dgain;
            default:                 coef_sel = '0;
        endcase
    end

    always_comb
    begin
        r_next    = r_reg;
        y_next    = y_reg;
        sign_next = sign_reg;
        mag_next  = mag_reg;
        prod_next = prod_reg;
        cnt_next  = cnt_reg;
        coef_next = coef_reg;
        rnd_next  = rnd_reg;
        case (ctrl.op)
            pidsw_pkg::OP_WAIT:
            begin
                if (in_valid)
                begin
                    r_next = in_reference;
                    y_next = in_measurement;
                end
            end
            pidsw_pkg::OP_ABS:
            begin
                sign_next = a_op[DW-1];
                mag_next  = MW'(abs_val);
                prod_next = '0;
                cnt_next  = '0;
                coef_next = coef_sel;
            end
            pidsw_pkg::OP_MUL:
            begin
                prod_next = (prod_reg << CW) + PWW'(part);
                mag_next  = mag_reg << CW;
                cnt_next  = cnt_reg + 1'b1;
            end
            pidsw_pkg::OP_RND:
            begin
                rnd_next = ACC_WIDTH'((rnd_sum > lim) ? lim : rnd_sum);
            end
            default:
            begin
            end
        endcase
    end

    // slot ram writes
    assign ram_we = ctrl.op inside {pidsw_pkg::OP_ZERO, pidsw_pkg::OP_ADD, pidsw_pkg::OP_SUB,
                                    pidsw_pkg::OP_MOV, pidsw_pkg::OP_SGN};

    always_comb
    begin
        case (ctrl.op)
            pidsw_pkg::OP_ADD: ram_wdata = alu_res;
            pidsw_pkg::OP_SUB: ram_wdata = alu_res;
            pidsw_pkg::OP_MOV: ram_wdata = b_op;
            pidsw_pkg::OP_SGN: ram_wdata = sgn_val;
            default:           ram_wdata = '0;
        endcase
    end

    pidsw_ram #(
        .WIDTH (DW),
        .DEPTH (pidsw_pkg::RAM_DEPTH)
    ) u_slots (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ctrl.dst),
        .wdata   (ram_wdata),
        .raddr_a (ctrl.rd_a),
        .raddr_b (ctrl.rd_b),
        .rdata_a (ram_qa),
        .rdata_b (ram_qb)
    );

    // output register with clipping to the sample range
    assign u_next   = ctrl.u_load ? alu_res : u_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (ctrl.op == pidsw_pkg::OP_OUT) && out_free;

    always_comb
    begin
        out_value_next = out_value_reg;
        out_sat_next   = out_sat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            if (u_reg > SMAX)
            begin
                out_value_next = SAMPLE_WIDTH'(SMAX);
                out_sat_next   = 1'b1;
            end
            else if (u_reg < SMIN)
            begin
                out_value_next = SAMPLE_WIDTH'(SMIN);
                out_sat_next   = 1'b1;
            end
            else
            begin
                out_value_next = SAMPLE_WIDTH'(u_reg);
                out_sat_next   = 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_sat   = out_sat_reg;

    assign cond.in_valid = in_valid;
    assign cond.mul_more = (cnt_reg != CNTW'(NCH - 1));
    assign cond.out_free = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg         <= r_next;
        y_reg         <= y_next;
        sign_reg      <= sign_next;
        mag_reg       <= mag_next;
        prod_reg      <= prod_next;
        cnt_reg       <= cnt_next;
        coef_reg      <= coef_next;
        rnd_reg       <= rnd_next;
        u_reg         <= u_next;
        out_value_reg <= out_value_next;
        out_sat_reg   <= out_sat_next;
    end

endmodule

FILE: hw/rtl/pid_setpoint_weight_filtered_d.sv
// top level of the pid controller with setpoint weighting and filtered derivative
//
// one item on the slave stream carries a reference and a measurement sample; for each
// one the block returns one item on the master stream: the control value p + i + d,
// clipped to the sample range, with tuser high when it was clipped.
// coefficients sit in five registers written through the cfg port, one per cycle;
// the user must write them only while the block is idle; the block does not enforce it.
// a microcode program steps a shared saturating adder and a coefficient multiplier
// over a small slot ram. each coefficient product runs over NCH 32-bit multiplier
// chunks, where NCH = ceil(max(ACC_WIDTH, SAMPLE_WIDTH) / 32); the next item is taken
// once the result is in the output register. after reset a clearing pass zeroes the
// integral, derivative and previous measurement; no item is taken during it.
// a stalled receiver holds the result in the output register; the block still accepts
// one more item and holds its result step until the register frees.
module pid_setpoint_weight_filtered_d #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int ACC_WIDTH      = 32,
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_wr_en,
    input  logic [pidsw_pkg::REG_IDX_W-1:0]           cfg_index,
    input  logic [pidsw_pkg::COEF_W-1:0]              cfg_wr_data,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // reference, measurement
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // control_value
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
    // saturated
    output logic                                      m_axis_tuser
);

    localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    pidsw_pkg::coefs_t coefs_reg, coefs_next;
    pidsw_pkg::ctrl_t  ctrl;
    pidsw_pkg::cond_t  cond;

    logic signed [SAMPLE_WIDTH-1:0] out_value;

    always_comb
    begin
        coefs_next = coefs_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                pidsw_pkg::REG_GAIN:     coefs_next.gain     = cfg_wr_data;
                pidsw_pkg::REG_WEIGHT:   coefs_next.weight   = cfg_wr_data;
                pidsw_pkg::REG_INTEGRAL: coefs_next.integral = cfg_wr_data;
                pidsw_pkg::REG_DECAY:    coefs_next.decay    = cfg_wr_data;
                pidsw_pkg::REG_DGAIN:    coefs_next.dgain    = cfg_wr_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.gain     <= pidsw_pkg::RESET_GAIN;
            coefs_reg.weight   <= pidsw_pkg::RESET_WEIGHT;
            coefs_reg.integral <= pidsw_pkg::RESET_INTEGRAL;
            coefs_reg.decay    <= pidsw_pkg::RESET_DECAY;
            coefs_reg.dgain    <= pidsw_pkg::RESET_DGAIN;
        end
        else
        begin
            coefs_reg <= coefs_next;
        end
    end

    pidsw_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    pidsw_datapath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .ACC_WIDTH      (ACC_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .coefs          (coefs_reg),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_reference   ($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])),
        .in_measurement ($signed(s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_value      (out_value),
        .out_sat        (m_axis_tuser),
        .cond           (cond)
    );

    assign m_axis_tdata = OUT_W'($unsigned(out_value));

endmodule
